>>> sv/pdjr_pkg.sv
`timescale 1ns / 1ps

package pdjr_pkg;

  localparam int unsigned MAX_AXES    = 6;
  localparam int unsigned DEF_AXES    = 6;
  localparam int unsigned LINEAR_AXES = 3;
  localparam int unsigned HIST_DEPTH  = 3;

  // pipeline: input, sum, magnitude, products, scale, divide, clamp, jump test
  localparam int unsigned NSTAGE = 8;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RATE_W  = 27;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned MAG_W   = SUM_W - 1;

  localparam logic [RATE_W-1:0]  RATE_RST    = 27'd655360;
  localparam logic [LIMIT_W-1:0] LIN_LIM_RST = 31'd4588;
  localparam logic [LIMIT_W-1:0] ANG_LIM_RST = 31'd1966;

  // rounding offset for the divide by 6 * 2^16
  localparam logic [63:0] HALF_DIV = 64'd196608;
  // 2^16 = 3 * 21845 + 1
  localparam logic [31:0] THIRD_OF_64K = 32'd21845;
  // ceil(2^19 / 3), exact for dividends below 2^19
  localparam logic [35:0] RECIP3 = 36'd174763;

  typedef enum logic [1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_LIN_LIMIT   = 2'd1,
    REG_ANG_LIMIT   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] roll;
    logic signed [DATA_W-1:0] pitch;
    logic signed [DATA_W-1:0] yaw;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] rate_roll;
    logic signed [DATA_W-1:0] rate_pitch;
    logic signed [DATA_W-1:0] rate_yaw;
    logic [MAX_AXES-1:0]      held_mask;
  } out_t;

  typedef struct packed {
    logic [NSTAGE-1:0] vld;
    logic [NSTAGE-1:0] adv;
  } pipe_ctrl_t;

endpackage

>>> sv/pdjr_axis.sv
`timescale 1ns / 1ps

module pdjr_axis (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pdjr_pkg::pipe_ctrl_t                  ctrl_i,
  input  logic signed [pdjr_pkg::DATA_W-1:0]    sample_i,
  input  logic [pdjr_pkg::RATE_W-1:0]           rate_i,
  input  logic [pdjr_pkg::LIMIT_W-1:0]          limit_i,
  output logic signed [pdjr_pkg::DATA_W-1:0]    vel_o,
  output logic                                  held_o
);
  import pdjr_pkg::*;

  logic signed [DATA_W-1:0] hist_q [HIST_DEPTH];
  logic signed [DATA_W-1:0] prev_q;

  // stage 1: six times the weighted difference
  logic signed [SUM_W-1:0] e0, e1, e2, e3;
  logic signed [SUM_W-1:0] s_d, s_q;

  assign e0 = SUM_W'(sample_i);
  assign e1 = SUM_W'(hist_q[0]);
  assign e2 = SUM_W'(hist_q[1]);
  assign e3 = SUM_W'(hist_q[2]);
  assign s_d = (e0 <<< 3) + (e0 <<< 1) + e0
             - (e1 <<< 4) - (e1 <<< 1)
             + (e2 <<< 3) + e2
             - (e3 <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_DEPTH; k++) hist_q[k] <= '0;
    end else if (ctrl_i.adv[1] && ctrl_i.vld[0]) begin
      hist_q[0] <= sample_i;
      for (int k = 1; k < HIST_DEPTH; k++) hist_q[k] <= hist_q[k-1];
    end
  end

  // stage 2: sign and magnitude
  logic             neg2_q;
  logic [MAG_W-1:0] mag_d, mag_q;

  assign mag_d = s_q[SUM_W-1] ? MAG_W'(-s_q) : MAG_W'(s_q);

  // stage 3: magnitude times rate as two partial products
  logic        neg3_q;
  logic [44:0] pp_hi_d, pp_hi_q;
  logic [45:0] pp_lo_d, pp_lo_q;

  assign pp_hi_d = 45'(mag_q[MAG_W-1:19]) * 45'(rate_i);
  assign pp_lo_d = 46'(mag_q[18:0]) * 46'(rate_i);

  // stage 4: round and drop the fraction; anything at or past 2^34 clamps anyway
  logic        neg4_q, big4_q;
  logic [63:0] prod;
  logic [33:0] t_d, t_q;
  logic        big_d;

  assign prod  = (64'(pp_hi_q) << 19) + 64'(pp_lo_q) + HALF_DIV;
  assign big_d = |prod[63:50];
  assign t_d   = prod[49:16];

  // stage 5: divide by 6 as halve, then split divide by 3
  logic        neg5_q, big5_q;
  logic [32:0] u;
  logic [16:0] uh;
  logic [15:0] ul;
  logic [17:0] v;
  logic [35:0] b;
  logic [31:0] a_d, a_q;
  logic [16:0] qlo_d, qlo_q;

  assign u     = t_q[33:1];
  assign uh    = u[32:16];
  assign ul    = u[15:0];
  assign a_d   = 32'(uh) * THIRD_OF_64K;
  assign v     = 18'(uh) + 18'(ul);
  assign b     = 36'(v) * RECIP3;
  assign qlo_d = b[35:19];

  // stage 6: signed candidate, clamped to the q16.16 range
  logic [32:0]              q;
  logic signed [DATA_W-1:0] cand_d, cand_q;

  assign q = 33'(a_q) + 33'(qlo_q);

  always_comb begin
    if (!neg5_q) begin
      if (big5_q || q > 33'h0_7FFF_FFFF) cand_d = 32'sh7FFF_FFFF;
      else                               cand_d = DATA_W'(q);
    end else begin
      if (big5_q || q > 33'h0_8000_0000) cand_d = 32'sh8000_0000;
      else                               cand_d = DATA_W'(-q);
    end
  end

  // stage 7: jump test against the last emitted value
  logic signed [DATA_W:0] dlt;
  logic [DATA_W:0]        adlt;
  logic                   hold;
  logic signed [DATA_W-1:0] vel_d, vel_q;
  logic                   held_q;

  assign dlt   = (DATA_W+1)'(cand_q) - (DATA_W+1)'(prev_q);
  assign adlt  = dlt[DATA_W] ? (DATA_W+1)'(-dlt) : (DATA_W+1)'(dlt);
  assign hold  = adlt > (DATA_W+1)'(limit_i);
  assign vel_d = hold ? prev_q : cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctrl_i.adv[7] && ctrl_i.vld[6]) begin
      prev_q <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[1]) s_q <= s_d;
    if (ctrl_i.adv[2]) begin
      neg2_q <= s_q[SUM_W-1];
      mag_q  <= mag_d;
    end
    if (ctrl_i.adv[3]) begin
      neg3_q  <= neg2_q;
      pp_hi_q <= pp_hi_d;
      pp_lo_q <= pp_lo_d;
    end
    if (ctrl_i.adv[4]) begin
      neg4_q <= neg3_q;
      big4_q <= big_d;
      t_q    <= t_d;
    end
    if (ctrl_i.adv[5]) begin
      neg5_q <= neg4_q;
      big5_q <= big4_q;
      a_q    <= a_d;
      qlo_q  <= qlo_d;
    end
    if (ctrl_i.adv[6]) cand_q <= cand_d;
    if (ctrl_i.adv[7]) begin
      vel_q  <= vel_d;
      held_q <= hold;
    end
  end

  assign vel_o  = vel_q;
  assign held_o = held_q;

endmodule

>>> sv/pose_differentiator_jump_reject.sv
`timescale 1ns / 1ps
// channel | direction | handshake                  | payload
// in      | into      | in_valid_i / in_stall_o    | in_data_i  (six pose axes)
// out     | out of    | out_valid_o / out_stall_i  | out_data_o (six rates, held mask)
// cfg     | into      | apb psel/penable/pready    | sample rate, two jump limits
//
// one beat per cycle sustained while out_stall_i is low; each accepted beat
// passes the stage registers (sum, magnitude, split multiply, scale, divide by 3,
// clamp, jump test) to the output register. the jump test and its previous-value
// register sit in the last stage, so back-to-back beats see each other's result.
// reset clears history, previous-value registers, valid bits and config to defaults.
// a stalled output only holds the stages behind it up to the first bubble.

module pose_differentiator_jump_reject #(
  parameter int unsigned AXES = pdjr_pkg::DEF_AXES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pdjr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pdjr_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdjr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pdjr_pkg::*;

  // configuration
  logic [RATE_W-1:0]  rate_q;
  logic [LIMIT_W-1:0] lin_lim_q, ang_lim_q;
  cfg_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RATE_RST;
      lin_lim_q <= LIN_LIM_RST;
      ang_lim_q <= ANG_LIM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SAMPLE_RATE: rate_q    <= pwdata[RATE_W-1:0];
        REG_LIN_LIMIT:   lin_lim_q <= pwdata[LIMIT_W-1:0];
        REG_ANG_LIMIT:   ang_lim_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SAMPLE_RATE: prdata = 32'(rate_q);
      REG_LIN_LIMIT:   prdata = 32'(lin_lim_q);
      REG_ANG_LIMIT:   prdata = 32'(ang_lim_q);
      default:         prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when empty or when the one after it moves
  logic [NSTAGE-1:0] vld_q, adv;
  pipe_ctrl_t        ctrl;

  always_comb begin
    adv[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE-2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign ctrl.vld    = vld_q;
  assign ctrl.adv    = adv;
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  // input register
  in_t in_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) in_q <= in_data_i;
  end

  logic signed [DATA_W-1:0] smp [MAX_AXES];
  logic signed [DATA_W-1:0] vel [MAX_AXES];
  logic [MAX_AXES-1:0]      held;

  assign smp[0] = in_q.pos_x;
  assign smp[1] = in_q.pos_y;
  assign smp[2] = in_q.pos_z;
  assign smp[3] = in_q.roll;
  assign smp[4] = in_q.pitch;
  assign smp[5] = in_q.yaw;

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_on
      pdjr_axis u_axis (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .sample_i (smp[i]),
        .rate_i   (rate_q),
        .limit_i  ((i < LINEAR_AXES) ? lin_lim_q : ang_lim_q),
        .vel_o    (vel[i]),
        .held_o   (held[i])
      );
    end else begin : g_off
      assign vel[i]  = '0;
      assign held[i] = 1'b0;
    end
  end

  assign out_data_o.vel_x      = vel[0];
  assign out_data_o.vel_y      = vel[1];
  assign out_data_o.vel_z      = vel[2];
  assign out_data_o.rate_roll  = vel[3];
  assign out_data_o.rate_pitch = vel[4];
  assign out_data_o.rate_yaw   = vel[5];
  assign out_data_o.held_mask  = held;

endmodule
